// ===== rtl/mbe_pkg.sv =====
// shared types, register map and constants of the mandelbrot escape-time block
package mbe_pkg;

  // escape count width and iteration cap
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned ITER_W   = 13;
  localparam logic [ITER_W-1:0] ITER_CAP = 13'd4096;

  // configuration port
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_DATA_W = 32;

  localparam logic [2:0] REG_ZOOM     = 3'd0;
  localparam logic [2:0] REG_CENTER_R = 3'd1;
  localparam logic [2:0] REG_CENTER_I = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_MAX_ITER = 3'd5;
  localparam logic [2:0] REG_SAT      = 3'd6;

  // reset values
  localparam logic [31:0]       RST_ZOOM     = 32'd32;
  localparam logic [31:0]       RST_CENTER   = 32'd0;
  localparam logic [ITER_W-1:0] RST_WIDTH    = 13'd1024;
  localparam logic [ITER_W-1:0] RST_HEIGHT   = 13'd768;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 13'd256;
  localparam logic [30:0]       RST_SAT      = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] zoom_step;
    logic signed [31:0] center_real;
    logic signed [31:0] center_imag;
    logic [ITER_W-1:0]  img_cols;
    logic [ITER_W-1:0]  img_rows;
    logic [ITER_W-1:0]  max_iterations;
    logic [30:0]        sat_limit;
  } cfg_t;

  // token that travels along the cell ring
  typedef struct packed {
    logic             active;
    logic             done;
    logic [CNT_W-1:0] count;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } state_e;

endpackage

// ===== rtl/mandelbrot_escape_time_fixed_top.sv =====
// top level of the fixed-point mandelbrot escape-time block: config, c setup, cell ring
// flow: c formed at the accept edge, first iteration in cell 0 during the load cycle, then
//   one per cycle as the request rides round the ring; a finished request leaves the ring
//   tail into the output register once that can take it, and keeps lapping while it stalls
// a single request owns the ring, so a new pixel is accepted only once the last has left it
// reset: asynchronous, active low; clears control state, empties the ring, loads defaults
module mandelbrot_escape_time_fixed_top #(
  parameter int unsigned FRAC_BITS = 15,
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned NUM_CELLS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::REG_DATA_W-1:0]     pwdata,
  output logic [mbe_pkg::REG_DATA_W-1:0]     prdata,
  output logic                               pready,
  // pixel requests
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [11:0]                        pixel_col_i,
  input  logic [11:0]                        pixel_row_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mbe_pkg::CNT_W-1:0]          escape_count_o
);

  mbe_pkg::cfg_t cfg;

  mbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // iteration limit, capped so that the count fits in 12 bits
  logic [mbe_pkg::ITER_W-1:0] limit, limit_m1;
  logic [mbe_pkg::CNT_W-1:0]  last_k;
  logic                       no_iter;

  always_comb begin
    limit    = (cfg.max_iterations > mbe_pkg::ITER_CAP) ? mbe_pkg::ITER_CAP
                                                          : cfg.max_iterations;
    limit_m1 = limit - 13'd1;
    last_k   = limit_m1[mbe_pkg::CNT_W-1:0];
    no_iter  = (limit == '0);
  end

  // point in the complex plane: centre + (index - size/2) * pitch, wrapped
  logic signed [12:0]             dx, dy;
  logic signed [DATA_BITS+12:0]   px, py;
  logic [DATA_BITS-1:0]           c_re_d, c_im_d, c_re_q, c_im_q;

  always_comb begin
    dx     = $signed({1'b0, pixel_col_i}) - $signed({1'b0, cfg.img_cols[12:1]});
    dy     = $signed({1'b0, pixel_row_i}) - $signed({1'b0, cfg.img_rows[12:1]});
    px     = (DATA_BITS+13)'(dx) * (DATA_BITS+13)'($signed(cfg.zoom_step[DATA_BITS-1:0]));
    py     = (DATA_BITS+13)'(dy) * (DATA_BITS+13)'($signed(cfg.zoom_step[DATA_BITS-1:0]));
    c_re_d = cfg.center_real[DATA_BITS-1:0] + px[DATA_BITS-1:0];
    c_im_d = cfg.center_imag[DATA_BITS-1:0] + py[DATA_BITS-1:0];
  end

  // sequencer
  mbe_pkg::state_e state_d, state_q;
  logic            in_acc;
  logic            load;
  logic            cap;

  mbe_pkg::tok_t        tail_tok;
  logic [DATA_BITS-1:0] tail_zr, tail_zi;

  assign in_acc = in_valid_i && in_ready_o;

  // a finished request leaves the ring only when the output register can take it,
  // otherwise it keeps travelling round
  assign cap = (state_q == mbe_pkg::ST_RUN) && tail_tok.active && tail_tok.done &&
               (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::ST_IDLE: if (in_valid_i) state_d = mbe_pkg::ST_LOAD;
      mbe_pkg::ST_LOAD: state_d = mbe_pkg::ST_RUN;
      mbe_pkg::ST_RUN:  if (cap) state_d = mbe_pkg::ST_IDLE;
      default:          state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      mbe_pkg::ST_IDLE: in_ready_o = 1'b1;
      mbe_pkg::ST_LOAD: load       = 1'b1;
      mbe_pkg::ST_RUN:  ;
      default:          ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
    end
  end

  // ring head: new request on load, empty slot on capture, otherwise wrap the tail round
  mbe_pkg::tok_t        head_tok;
  logic [DATA_BITS-1:0] head_zr, head_zi;

  always_comb begin
    head_tok = tail_tok;
    head_zr  = tail_zr;
    head_zi  = tail_zi;
    priority if (load) begin
      head_tok.active = 1'b1;
      head_tok.done   = no_iter;
      head_tok.count  = no_iter ? last_k : '0;
      head_zr         = c_re_q;
      head_zi         = c_im_q;
    end else if (cap) begin
      head_tok = '0;
    end
  end

  // cell ring
  mbe_pkg::tok_t        tok [NUM_CELLS];
  logic [DATA_BITS-1:0] zr  [NUM_CELLS];
  logic [DATA_BITS-1:0] zi  [NUM_CELLS];
  logic [NUM_CELLS-1:0] act;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbe_pkg::tok_t        t_in;
    logic [DATA_BITS-1:0] zr_in, zi_in;

    if (g == 0) begin : g_head
      assign t_in  = head_tok;
      assign zr_in = head_zr;
      assign zi_in = head_zi;
    end else begin : g_link
      assign t_in  = tok[g-1];
      assign zr_in = zr[g-1];
      assign zi_in = zi[g-1];
    end

    mbe_cell #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sat_i    (cfg.sat_limit),
      .last_k_i (last_k),
      .c_re_i   (c_re_q),
      .c_im_i   (c_im_q),
      .tok_i    (t_in),
      .zr_i     (zr_in),
      .zi_i     (zi_in),
      .tok_o    (tok[g]),
      .zr_o     (zr[g]),
      .zi_o     (zi[g])
    );

    assign act[g] = tok[g].active;
  end

  assign tail_tok = tok[NUM_CELLS-1];
  assign tail_zr  = zr[NUM_CELLS-1];
  assign tail_zi  = zi[NUM_CELLS-1];

  // output register, parts the ring from the result side
  logic                      out_valid_d, out_valid_q;
  logic [mbe_pkg::CNT_W-1:0] count_q;

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cap) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      count_q <= tail_tok.count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = count_q;

  // at most one request lives in the ring
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(act) <= 1)
    else $error("more than one request in the cell ring");

  // while running the request is somewhere in the ring
  a_run_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbe_pkg::ST_RUN) |-> ($countones(act) == 1))
    else $error("request lost from the cell ring");

  // outside a run the ring is empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mbe_pkg::ST_RUN) |-> (act == '0))
    else $error("cell ring busy outside a run");

endmodule

// ===== rtl/mbe_regs.sv =====
// apb-style configuration registers of the mandelbrot escape-time block
module mbe_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::REG_DATA_W-1:0]     pwdata,
  output logic [mbe_pkg::REG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output mbe_pkg::cfg_t                      cfg_o
);

  mbe_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom_step      <= mbe_pkg::RST_ZOOM;
      cfg_q.center_real    <= mbe_pkg::RST_CENTER;
      cfg_q.center_imag    <= mbe_pkg::RST_CENTER;
      cfg_q.img_cols       <= mbe_pkg::RST_WIDTH;
      cfg_q.img_rows       <= mbe_pkg::RST_HEIGHT;
      cfg_q.max_iterations <= mbe_pkg::RST_MAX_ITER;
      cfg_q.sat_limit      <= mbe_pkg::RST_SAT;
    end else if (wr_en) begin
      unique case (idx)
        mbe_pkg::REG_ZOOM:     cfg_q.zoom_step      <= pwdata;
        mbe_pkg::REG_CENTER_R: cfg_q.center_real    <= pwdata;
        mbe_pkg::REG_CENTER_I: cfg_q.center_imag    <= pwdata;
        mbe_pkg::REG_WIDTH:    cfg_q.img_cols       <= pwdata[12:0];
        mbe_pkg::REG_HEIGHT:   cfg_q.img_rows       <= pwdata[12:0];
        mbe_pkg::REG_MAX_ITER: cfg_q.max_iterations <= pwdata[12:0];
        mbe_pkg::REG_SAT:      cfg_q.sat_limit      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mbe_pkg::REG_ZOOM:     prdata = cfg_q.zoom_step;
      mbe_pkg::REG_CENTER_R: prdata = cfg_q.center_real;
      mbe_pkg::REG_CENTER_I: prdata = cfg_q.center_imag;
      mbe_pkg::REG_WIDTH:    prdata = {19'd0, cfg_q.img_cols};
      mbe_pkg::REG_HEIGHT:   prdata = {19'd0, cfg_q.img_rows};
      mbe_pkg::REG_MAX_ITER: prdata = {19'd0, cfg_q.max_iterations};
      mbe_pkg::REG_SAT:      prdata = {1'b0, cfg_q.sat_limit};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== rtl/mbe_cell.sv =====
// one iteration cell of the ring: z = z^2 + c with clamp, wrap and escape test
module mbe_cell #(
  parameter int unsigned FRAC_BITS = 15,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [30:0]                        sat_i,
  input  logic [mbe_pkg::CNT_W-1:0]          last_k_i,
  input  logic [DATA_BITS-1:0]               c_re_i,
  input  logic [DATA_BITS-1:0]               c_im_i,
  input  mbe_pkg::tok_t                      tok_i,
  input  logic [DATA_BITS-1:0]               zr_i,
  input  logic [DATA_BITS-1:0]               zi_i,
  output mbe_pkg::tok_t                      tok_o,
  output logic [DATA_BITS-1:0]               zr_o,
  output logic [DATA_BITS-1:0]               zi_o
);

  localparam int unsigned PW = 2 * DATA_BITS - FRAC_BITS;
  localparam int unsigned CW = ((PW > 31) ? PW : 31) + 1;
  localparam int unsigned TW = ((DATA_BITS + 1) > (FRAC_BITS + 4)) ?
                               (DATA_BITS + 1) : (FRAC_BITS + 4);

  // shift, clamp from above, wrap
  function automatic logic [DATA_BITS-1:0] scale(input logic [2*DATA_BITS-1:0] p,
                                                 input logic [30:0] sat);
    logic [PW-1:0] ps;
    logic [CW-1:0] pe;
    logic [CW-1:0] se;
    logic [CW-1:0] cl;
    ps = p[2*DATA_BITS-1:FRAC_BITS];
    pe = {{(CW-PW){ps[PW-1]}}, ps};
    se = {{(CW-31){1'b0}}, sat};
    cl = ($signed(pe) >= $signed(se)) ? se : pe;
    return cl[DATA_BITS-1:0];
  endfunction

  logic signed [2*DATA_BITS-1:0] p_rr, p_ii, p_ri;
  logic [DATA_BITS-1:0]          r2, i2, ri, zr_new, zi_new;
  logic [TW-1:0]                 mag, thresh;
  logic                          escape;
  mbe_pkg::tok_t                 tok_d, tok_q;
  logic [DATA_BITS-1:0]          zr_d, zr_q, zi_d, zi_q;

  always_comb begin
    p_rr   = (2*DATA_BITS)'($signed(zr_i)) * (2*DATA_BITS)'($signed(zr_i));
    p_ii   = (2*DATA_BITS)'($signed(zi_i)) * (2*DATA_BITS)'($signed(zi_i));
    p_ri   = (2*DATA_BITS)'($signed(zr_i)) * (2*DATA_BITS)'($signed(zi_i));
    r2     = scale(p_rr, sat_i);
    i2     = scale(p_ii, sat_i);
    ri     = scale(p_ri, sat_i);
    zi_new = {ri[DATA_BITS-2:0], 1'b0} + c_im_i;
    zr_new = r2 - i2 + c_re_i;
    mag    = {{(TW-DATA_BITS){r2[DATA_BITS-1]}}, r2}
           + {{(TW-DATA_BITS){i2[DATA_BITS-1]}}, i2};
    thresh = {{(TW-3){1'b0}}, 3'b100} << FRAC_BITS;
    escape = $signed(mag) > $signed(thresh);
  end

  always_comb begin
    tok_d = tok_i;
    zr_d  = zr_i;
    zi_d  = zi_i;
    if (tok_i.active && !tok_i.done) begin
      zr_d = zr_new;
      zi_d = zi_new;
      if (escape || (tok_i.count == last_k_i)) begin
        tok_d.done = 1'b1;
      end else begin
        tok_d.count = tok_i.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_d;
    zi_q <= zi_d;
  end

  assign tok_o = tok_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;

endmodule

// ===== tb/mandelbrot_escape_time_fixed_top_tb.sv =====
// self-checking testbench for the fixed-point mandelbrot escape-time block
`timescale 1ns / 100ps

module mandelbrot_escape_time_fixed_top_tb;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned DATA_BITS = 32;
  // escape threshold, 4.0 in the block's fixed-point format
  localparam longint ESC_LIMIT = longint'(4) << FRAC_BITS;
  // one in the block's fixed-point format
  localparam int ONE = 32768;
  // clamp that never bites, as a register value
  localparam logic [31:0] SAT_MAX = {1'b0, mbe_pkg::RST_SAT};
  // settle time after the last result: ring length plus register stages, with margin
  localparam int unsigned SETTLE_CYCLES = 32;
  // slowest correct run: about 800 requests at up to 256 iterations each, plus ring,
  // sender gaps and receiver stalls, plus a handful at the 4096 cap; the limit covers
  // that total several times over
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [mbe_pkg::REG_ADDR_W-1:0] paddr   = '0;
  logic [mbe_pkg::REG_DATA_W-1:0] pwdata  = '0;
  logic [mbe_pkg::REG_DATA_W-1:0] prdata;
  logic                           pready;

  // pixel requests and results
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [11:0]               pixel_col_i = '0;
  logic [11:0]               pixel_row_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [mbe_pkg::CNT_W-1:0] escape_count_o;

  // testbench state
  mbe_pkg::cfg_t             cfg;                // copy of the register file
  logic [mbe_pkg::CNT_W-1:0] expected_counts[$]; // escape counts still owed by the block
  int unsigned               mismatch_cnt = 0;
  int unsigned               cycle_cnt    = 0;
  int unsigned               ready_run    = 0;
  logic                      idle_on      = 1'b0;

  mandelbrot_escape_time_fixed_top #(
    .FRAC_BITS(FRAC_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .escape_count_o(escape_count_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact product, arithmetic shift, clamp from above at the saturation limit,
  // then wrap back to the data width
  function automatic longint scaled_prod(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    p = p >>> FRAC_BITS;
    if (p >= longint'(cfg.sat_limit))
      p = longint'(cfg.sat_limit);
    return longint'($signed(p[31:0]));
  endfunction

  // escape step of one pixel under the current register copy
  function automatic logic [mbe_pkg::CNT_W-1:0] escape_steps(logic [11:0] col,
                                                             logic [11:0] row);
    logic [31:0]               c_re, c_im, z_re, z_im;
    longint                    r2, i2, ri;
    int unsigned               limit, k;
    logic                      escaped;
    logic [mbe_pkg::CNT_W-1:0] steps;
    limit = 32'((cfg.max_iterations > mbe_pkg::ITER_CAP) ? mbe_pkg::ITER_CAP
                                                         : cfg.max_iterations);
    // no escape: limit minus one, which wraps to all ones for a zero limit
    steps = mbe_pkg::CNT_W'(limit - 1);
    // point in the plane, wrapping at the data width
    c_re = cfg.center_real - 32'(cfg.img_cols >> 1) * cfg.zoom_step
           + 32'(col) * cfg.zoom_step;
    c_im = cfg.center_imag - 32'(cfg.img_rows >> 1) * cfg.zoom_step
           + 32'(row) * cfg.zoom_step;
    z_re = c_re;
    z_im = c_im;
    escaped = 1'b0;
    k = 0;
    while (k < limit && !escaped) begin
      r2 = scaled_prod(z_re, z_re);
      i2 = scaled_prod(z_im, z_im);
      ri = scaled_prod(z_re, z_im);
      // magnitude check one bit wider, so it cannot wrap
      if (r2 + i2 > ESC_LIMIT) begin
        steps   = mbe_pkg::CNT_W'(k);
        escaped = 1'b1;
      end else begin
        z_im = 32'(ri << 1) + c_im;
        z_re = 32'(r2 - i2) + c_re;
      end
      k++;
    end
    return steps;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls while idling is on: random runs of ready high and random bursts low
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_ready_i <= 1'b1;
      ready_run   <= 0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (out_ready_i && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      ready_run   <= $urandom_range(0, 13);
    end else begin
      out_ready_i <= 1'b1;
      ready_run   <= $urandom_range(0, 20);
    end
  end

  // every accepted result against the oldest outstanding prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        $error("escape_count: unexpected result, expected none, actual %0d",
               escape_count_o);
        mismatch_cnt++;
      end else if (escape_count_o !== expected_counts[0]) begin
        $error("escape_count: expected %0d, actual %0d",
               expected_counts[0], escape_count_o);
        mismatch_cnt++;
        void'(expected_counts.pop_front());
      end else begin
        void'(expected_counts.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side and register access
  // ---------------------------------------------------------------------------

  // one pixel request; valid is left high so a following request can go out
  // back to back, and is dropped only for a sender gap
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    expected_counts.push_back(escape_steps(col, row));
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle until pready; the copy follows the write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      mbe_pkg::REG_ZOOM:     cfg.zoom_step      = value;
      mbe_pkg::REG_CENTER_R: cfg.center_real    = value;
      mbe_pkg::REG_CENTER_I: cfg.center_imag    = value;
      mbe_pkg::REG_WIDTH:    cfg.img_cols       = value[mbe_pkg::ITER_W-1:0];
      mbe_pkg::REG_HEIGHT:   cfg.img_rows       = value[mbe_pkg::ITER_W-1:0];
      mbe_pkg::REG_MAX_ITER: cfg.max_iterations = value[mbe_pkg::ITER_W-1:0];
      mbe_pkg::REG_SAT:      cfg.sat_limit      = value[30:0];
      default: ;
    endcase
  endtask

  // whole view at once, only once the block has drained
  task automatic set_view(input logic [31:0] zoom, input logic [31:0] c_re,
                          input logic [31:0] c_im, input logic [31:0] width,
                          input logic [31:0] height, input logic [31:0] iters,
                          input logic [31:0] sat);
    wait_for_results();
    write_reg(mbe_pkg::REG_ZOOM, zoom);
    write_reg(mbe_pkg::REG_CENTER_R, c_re);
    write_reg(mbe_pkg::REG_CENTER_I, c_im);
    write_reg(mbe_pkg::REG_WIDTH, width);
    write_reg(mbe_pkg::REG_HEIGHT, height);
    write_reg(mbe_pkg::REG_MAX_ITER, iters);
    write_reg(mbe_pkg::REG_SAT, sat);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly inside the image, sometimes anywhere in the 12-bit range
  function automatic logic [11:0] pick_coord(logic [mbe_pkg::ITER_W-1:0] size);
    if (size == 0 || $urandom_range(0, 9) == 0)
      return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, ((size > mbe_pkg::ITER_CAP) ? mbe_pkg::ITER_CAP
                                                              : size) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset view: an image corner, the centre and the largest indices
  task automatic test_reset_defaults();
    idle_on <= 1'b1;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512, 12'd384);
  endtask

  // full-plane view, corners and centre of the image and indices outside it
  task automatic test_directed_corners();
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd64, SAT_MAX);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd63, 12'd63);
    send_pixel(12'd63, 12'd0);
    send_pixel(12'd0, 12'd63);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
  endtask

  // zero limit, single step, the cap and a limit above the cap
  task automatic test_iteration_limits();
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd0, SAT_MAX);
    send_pixel(12'd32, 12'd32);
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd1, SAT_MAX);
    send_pixel(12'd32, 12'd32);
    // point inside the set, so every step of the cap runs
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd4096, SAT_MAX);
    send_pixel(12'd32, 12'd32);
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd8191, SAT_MAX);
    send_pixel(12'd32, 12'd32);
  endtask

  // zero and largest sizes, extreme pitch and centre, clamp and wrap cases
  task automatic test_clamp_and_wrap();
    // zero half size in both directions
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd0, 32'd0, 32'd64, SAT_MAX);
    send_pixel(12'd5, 12'd5);
    // largest register width and a height of 4096
    set_view(32'd1, 32'd0, 32'd0, 32'd8191, 32'd4096, 32'd64, SAT_MAX);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    // most negative pitch with extreme centres, point set-up wraps
    set_view(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd3, 32'd5, 32'd8, SAT_MAX);
    send_pixel(12'd1, 12'd3);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    // zero clamp keeps squares at zero while a large negative cross term wraps
    set_view(32'd0, 32'h0123_4567, 32'hfedc_ba98, 32'd16, 32'd16, 32'd40, 32'd0);
    send_pixel(12'd0, 12'd0);
    // clamp at 2.0
    set_view(32'd2048, -32'sd16384, 32'd0, 32'd64, 32'd64, 32'd64, 32'h0001_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd10, 12'd50);
  endtask

  // random views: mostly sensible windows onto the set, some wild settings
  task automatic test_random_views();
    int          zoom, c_re, c_im;
    int unsigned width, height, iters, sat;
    for (int phase = 0; phase < 12; phase++) begin
      idle_on <= ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 7) begin
        width  = $urandom_range(1, 256);
        height = $urandom_range(1, 256);
        // about three units across, zoomed in by a random power of two
        zoom   = (3 * ONE / width) >> $urandom_range(0, 8);
        if (zoom == 0)
          zoom = 1;
        c_re   = int'($urandom_range(0, 3 * ONE)) - 2 * ONE;
        c_im   = int'($urandom_range(0, 2 * ONE)) - ONE;
        iters  = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(1, 64);
        sat    = ($urandom_range(0, 3) == 0) ? $urandom_range(ONE, 1 << 20) : SAT_MAX;
      end else begin
        zoom   = $urandom();
        c_re   = $urandom();
        c_im   = $urandom();
        width  = $urandom_range(0, 8191);
        height = $urandom_range(0, 8191);
        iters  = $urandom_range(0, 48);
        sat    = $urandom_range(0, 32'h7fff_ffff);
      end
      set_view(zoom, c_re, c_im, width, height, iters, sat);
      repeat (50) send_pixel(pick_coord(cfg.img_cols), pick_coord(cfg.img_rows));
    end
  endtask

  // sender holds off until the block has returned everything, then resumes
  task automatic test_drain_pause();
    idle_on <= 1'b1;
    set_view(32'd1536, -32'sd16384, 32'd0, 32'd64, 32'd48, 32'd16, SAT_MAX);
    repeat (30) send_pixel(pick_coord(cfg.img_cols), pick_coord(cfg.img_rows));
    wait_for_results();
    repeat (30) send_pixel(pick_coord(cfg.img_cols), pick_coord(cfg.img_rows));
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    idle_on <= 1'b0;
    set_view(32'd768, -32'sd16384, 32'd0, 32'd128, 32'd96, 32'd32, SAT_MAX);
    repeat (100) send_pixel(pick_coord(cfg.img_cols), pick_coord(cfg.img_rows));
  endtask

  initial begin
    // register copy starts at the reset values
    cfg.zoom_step      = mbe_pkg::RST_ZOOM;
    cfg.center_real    = mbe_pkg::RST_CENTER;
    cfg.center_imag    = mbe_pkg::RST_CENTER;
    cfg.img_cols       = mbe_pkg::RST_WIDTH;
    cfg.img_rows       = mbe_pkg::RST_HEIGHT;
    cfg.max_iterations = mbe_pkg::RST_MAX_ITER;
    cfg.sat_limit      = mbe_pkg::RST_SAT;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_corners();
    test_iteration_limits();
    test_clamp_and_wrap();
    test_random_views();
    test_drain_pause();
    test_back_to_back();

    // everything owed has to arrive, then nothing more may follow
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mbe_pkg.sv
rtl/mbe_regs.sv
rtl/mbe_cell.sv
rtl/mandelbrot_escape_time_fixed_top.sv
tb/mandelbrot_escape_time_fixed_top_tb.sv
